@@ sv/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and keyword tables for the C token classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int unsigned KW_COUNT  = 26;
  localparam int unsigned KW_MAXLEN = 8;
  localparam logic [3:0]  POS_SAT   = 4'd9;

  localparam logic [7:0] CH_UNDER = 8'h5f;  // '_'
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // Keywords left-justified in 64 bits, first character in the top byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"auto", 32'h0},     {"int", 40'h0},      {"char", 32'h0},
    {"long", 32'h0},     {"float", 24'h0},    {"double", 16'h0},
    {"struct", 16'h0},   {"if", 48'h0},       {"else", 32'h0},
    {"break", 24'h0},    {"continue"},        {"while", 24'h0},
    {"do", 48'h0},       {"for", 40'h0},      {"return", 16'h0},
    {"signed", 16'h0},   {"unsigned"},        {"default", 8'h0},
    {"goto", 32'h0},     {"case", 32'h0},     {"sizeof", 16'h0},
    {"short", 24'h0},    {"switch", 16'h0},   {"void", 32'h0},
    {"static", 16'h0},   {"typedef", 8'h0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6, 4'd2, 4'd4,
    4'd5, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6, 4'd6, 4'd8, 4'd7,
    4'd4, 4'd4, 4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd7
  };

  // Classification of one finished token, front to back.
  typedef struct packed {
    logic kw_hit;
    logic ident_ok;
    logic op_seen;
  } ctc_class_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] p);
    logic [63:0] txt;
    txt = KW_TEXT[k];
    return txt[(7 - int'(p)) * 8 +: 8];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

@@ sv/ctc_front.sv @@
// ----------------------------------------------------------------------------
// ctc_front
// Per-character keyword match, identifier and operator tracking.
// ----------------------------------------------------------------------------
module ctc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                last,
  output logic                push,
  output ctc_pkg::ctc_class_t push_data
);
  import ctc_pkg::*;

  logic [KW_COUNT-1:0] alive_r, alive_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic                ident_r, ident_nxt;
  logic                op_r, op_nxt;
  logic                kw_hit;
  logic                ch_ok;

  always_comb begin
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      alive_nxt[k] = alive_r[k] && (pos_r < KW_LEN[k]) && (kw_char(k, pos_r[2:0]) == ch);
    end
    pos_nxt = (pos_r >= POS_SAT) ? POS_SAT : pos_r + 4'd1;
    kw_hit  = 1'b0;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      if (alive_nxt[k] && KW_LEN[k] == pos_nxt) kw_hit = 1'b1;
    end
    if (pos_r == 4'd0) begin
      ch_ok = is_letter(ch) || ch == CH_UNDER;
    end else begin
      ch_ok = is_letter(ch) || is_digit(ch) || ch == CH_UNDER;
    end
    ident_nxt = ident_r && ch_ok;
    op_nxt    = op_r || ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
                ch == CH_SLASH || ch == CH_PCT;
  end

  assign push               = accept && last;
  assign push_data.kw_hit   = kw_hit;
  assign push_data.ident_ok = ident_nxt;
  assign push_data.op_seen  = op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      alive_r <= '1;
      pos_r   <= 4'd0;
      ident_r <= 1'b1;
      op_r    <= 1'b0;
    end else if (accept) begin
      alive_r <= alive_nxt;
      pos_r   <= pos_nxt;
      ident_r <= ident_nxt;
      op_r    <= op_nxt;
    end
  end

  // token state must be back at reset after a final character
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (pos_r == 4'd0 && alive_r == '1 && ident_r && !op_r))
    else $error("front state not restarted after last character");

endmodule

@@ sv/ctc_queue.sv @@
// ----------------------------------------------------------------------------
// ctc_queue
// Small FIFO of token classifications between front and back.
// ----------------------------------------------------------------------------
module ctc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ctc_pkg::ctc_class_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output ctc_pkg::ctc_class_t head
);
  import ctc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ctc_class_t        mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

@@ sv/ctc_back.sv @@
// ----------------------------------------------------------------------------
// ctc_back
// Final flag resolution and output register.
// ----------------------------------------------------------------------------
module ctc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ctc_pkg::ctc_class_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_keyword,
  output logic                out_is_variable,
  output logic                out_is_operator
);
  import ctc_pkg::*;

  logic valid_r;
  logic kw_r, var_r, op_r;

  assign pop = q_valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kw_r  <= q_head.kw_hit;
      var_r <= !q_head.kw_hit && q_head.ident_ok;
      op_r  <= q_head.op_seen;
    end
  end

  assign out_valid       = valid_r;
  assign out_is_keyword  = kw_r;
  assign out_is_variable = var_r;
  assign out_is_operator = op_r;

endmodule

@@ sv/c_token_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// c_token_classifier_unit
// Classifies C tokens streamed one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one byte of a whitespace-free token
//   per transaction in in_ch, with in_last set on the token's final byte.
//   Output channel (out_valid/out_stall): one transaction per token with
//   keyword, identifier and operator flags; none for non-final bytes.
// Throughput: one character per cycle, sustained, as long as the receiver
//   drains results; the front keyword/identifier tracker updates on every accepted byte.
// Path: the queue takes the result at the edge that accepts the last
//   byte, and the output register loads it from the queue head once that
//   register is empty or not stalled, which raises out_valid.
// Stall: results wait in a QUEUE_DEPTH-entry queue; in_stall rises only
//   once that queue is full, so the input keeps flowing while the receiver
//   holds off for a while.
// Reset: synchronous rst_n clears the token state, empties the queue and
//   drops out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module c_token_classifier_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_keyword,
  output logic       out_is_variable,
  output logic       out_is_operator
);
  import ctc_pkg::*;

  logic       accept;
  logic       push, pop, q_full, q_valid;
  ctc_class_t push_data, q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  ctc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_ch),
    .last      (in_last),
    .push      (push),
    .push_data (push_data)
  );

  ctc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ctc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_keyword  (out_is_keyword),
    .out_is_variable (out_is_variable),
    .out_is_operator (out_is_operator)
  );

endmodule
